FILE: rtl/csm_pkg.sv
// Shared types and constants for the closed interval set manager.
// No dependencies; csm_seq, the top level and the checker use this package.
package csm_pkg;

    localparam int MAX_INTERVALS = 32;
    localparam int COORD_BITS    = 16;
    localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
    localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);
    localparam int VAL_BITS      = COORD_BITS + 1;
    localparam int ENTRY_BITS    = 2 * COORD_BITS;

    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;
    localparam logic [1:0] ACT_MEX    = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ORDER = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]            action;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
    } in_item_t;

    typedef struct packed {
        logic [VAL_BITS-1:0]   value;
        logic                  hit;
        logic [COORD_BITS-1:0] found_lo;
        logic [COORD_BITS-1:0] found_hi;
        logic [CNT_BITS-1:0]   interval_count;
        logic [1:0]            status;
    } out_item_t;

    typedef struct packed {
        logic                  re;
        logic [IDX_BITS-1:0]   raddr;
        logic                  we;
        logic [IDX_BITS-1:0]   waddr;
        logic [ENTRY_BITS-1:0] wdata;
    } mem_ctl_t;

endpackage

FILE: rtl/csm_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module csm_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/csm_seq.sv
// Request sequencer: walks the sorted table one entry at a time and, for an
// insert or erase, rebuilds it into the spare bank. Depends on csm_pkg.
module csm_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  csm_pkg::in_item_t                   item,
    output logic                                ready,
    input  logic [csm_pkg::ENTRY_BITS-1:0]      rd_data,
    output csm_pkg::mem_ctl_t                   mem_ctl,
    output logic                                bank,
    output logic                                res_valid,
    output csm_pkg::out_item_t                  res,
    input  logic                                res_take
);
    import csm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_EMIT2 = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            act_reg, act_next;
    logic [COORD_BITS-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_BITS-1:0]   idx_reg, idx_next, ncnt_reg, ncnt_next, count_reg, count_next;
    logic                  ovf_reg, ovf_next, placed_reg, placed_next;
    logic                  bank_reg, bank_next, hit_reg, hit_next;
    logic [COORD_BITS-1:0] ml_reg, ml_next, mr_reg, mr_next;
    logic [COORD_BITS-1:0] flo_reg, flo_next, fhi_reg, fhi_next;
    logic [VAL_BITS-1:0]   acc_reg, acc_next, val_reg, val_next;
    logic [1:0]            status_reg, status_next;

    logic [COORD_BITS-1:0] l, r, ea, eb;
    logic [VAL_BITS-1:0]   l_x, r_x, lo_x, hi_x, r_inc, hi_inc, ers_len, ent_len;
    logic                  ins_left, ins_right, ers_keep, full, two;
    logic                  emit_en, ovf_fin;
    logic [COORD_BITS-1:0] emit_l, emit_r;
    logic [CNT_BITS-1:0]   idx_inc, ncnt_fin;

    assign l       = rd_data[ENTRY_BITS-1:COORD_BITS];
    assign r       = rd_data[COORD_BITS-1:0];
    assign l_x     = {1'b0, l};
    assign r_x     = {1'b0, r};
    assign lo_x    = {1'b0, lo_reg};
    assign hi_x    = {1'b0, hi_reg};
    assign r_inc   = r_x + 1'b1;
    assign hi_inc  = hi_x + 1'b1;
    assign ins_left  = r_inc < lo_x;
    assign ins_right = l_x > hi_inc;
    assign ers_keep  = (r < lo_reg) || (l > hi_reg);
    assign ea      = (l > lo_reg) ? l : lo_reg;
    assign eb      = (r < hi_reg) ? r : hi_reg;
    assign ers_len = {1'b0, eb} - {1'b0, ea} + 1'b1;
    assign ent_len = r_x - l_x + 1'b1;
    assign full    = ncnt_reg == CNT_BITS'(MAX_INTERVALS);
    assign idx_inc = idx_reg + 1'b1;
    assign ovf_fin  = ovf_reg || (emit_en && full);
    assign ncnt_fin = ncnt_reg + CNT_BITS'(emit_en && !full);

    assign ready     = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign bank      = bank_reg;

    always_comb
    begin
        res.value          = val_reg;
        res.hit            = hit_reg;
        res.found_lo       = flo_reg;
        res.found_hi       = fhi_reg;
        res.interval_count = count_reg;
        res.status         = status_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        ncnt_next   = ncnt_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        placed_next = placed_reg;
        bank_next   = bank_reg;
        hit_next    = hit_reg;
        ml_next     = ml_reg;
        mr_next     = mr_reg;
        flo_next    = flo_reg;
        fhi_next    = fhi_reg;
        acc_next    = acc_reg;
        val_next    = val_reg;
        status_next = status_reg;
        emit_en     = 1'b0;
        emit_l      = '0;
        emit_r      = '0;
        two         = 1'b0;
        mem_ctl.re    = 1'b0;
        mem_ctl.raddr = idx_reg[IDX_BITS-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next    = item.action;
                    lo_next     = item.lo;
                    hi_next     = item.hi;
                    idx_next    = '0;
                    ncnt_next   = '0;
                    ovf_next    = 1'b0;
                    placed_next = 1'b0;
                    ml_next     = item.lo;
                    mr_next     = item.hi;
                    hit_next    = 1'b0;
                    flo_next    = '0;
                    fhi_next    = '0;
                    val_next    = '0;
                    status_next = STAT_OK;
                    acc_next    = (item.action == ACT_MEX) ? {1'b0, item.lo} : '0;
                    if (item.action != ACT_MEX && item.lo > item.hi)
                    begin
                        status_next = STAT_ORDER;
                        state_next  = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                mem_ctl.re = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                idx_next = idx_inc;
                case (act_reg)
                    ACT_QUERY:
                    begin
                        if (l <= lo_reg && hi_reg <= r)
                        begin
                            hit_next = 1'b1;
                            flo_next = l;
                            fhi_next = r;
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (ins_left)
                        begin
                            emit_en = 1'b1;
                            emit_l  = l;
                            emit_r  = r;
                        end
                        else if (ins_right)
                        begin
                            emit_en = 1'b1;
                            if (!placed_reg)
                            begin
                                emit_l      = ml_reg;
                                emit_r      = mr_reg;
                                placed_next = 1'b1;
                                two         = 1'b1;
                            end
                            else
                            begin
                                emit_l = l;
                                emit_r = r;
                            end
                        end
                        else
                        begin
                            if (l < ml_reg)
                            begin
                                ml_next = l;
                            end
                            if (r > mr_reg)
                            begin
                                mr_next = r;
                            end
                            acc_next = acc_reg + ent_len;
                        end
                    end
                    ACT_ERASE:
                    begin
                        if (ers_keep)
                        begin
                            emit_en = 1'b1;
                            emit_l  = l;
                            emit_r  = r;
                        end
                        else
                        begin
                            acc_next = acc_reg + ers_len;
                            if (l < lo_reg)
                            begin
                                emit_en = 1'b1;
                                emit_l  = l;
                                emit_r  = lo_reg - 1'b1;
                                two     = r > hi_reg;
                            end
                            else if (r > hi_reg)
                            begin
                                emit_en = 1'b1;
                                emit_l  = hi_inc[COORD_BITS-1:0];
                                emit_r  = r;
                            end
                        end
                    end
                    default:
                    begin
                        if (l <= lo_reg && lo_reg <= r)
                        begin
                            acc_next = r_inc;
                        end
                    end
                endcase
                if (two)
                begin
                    state_next = ST_EMIT2;
                end
                else
                begin
                    state_next = (idx_inc == count_reg) ? ST_FIN : ST_READ;
                end
            end
            ST_EMIT2:
            begin
                emit_en = 1'b1;
                emit_r  = r;
                emit_l  = (act_reg == ACT_INSERT) ? l : hi_inc[COORD_BITS-1:0];
                state_next = (idx_reg == count_reg) ? ST_FIN : ST_READ;
            end
            ST_FIN:
            begin
                if (act_reg == ACT_INSERT && !placed_reg)
                begin
                    emit_en = 1'b1;
                    emit_l  = ml_reg;
                    emit_r  = mr_reg;
                end
                case (act_reg)
                    ACT_QUERY:  val_next = '0;
                    ACT_INSERT: val_next = {1'b0, mr_reg} - {1'b0, ml_reg} + 1'b1 - acc_reg;
                    default:    val_next = acc_reg;
                endcase
                if (act_reg == ACT_INSERT || act_reg == ACT_ERASE)
                begin
                    if (ovf_fin)
                    begin
                        status_next = STAT_FULL;
                        val_next    = '0;
                    end
                    else
                    begin
                        bank_next  = !bank_reg;
                        count_next = ncnt_fin;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // write each emitted entry into the spare bank, or flag overflow
        mem_ctl.we    = emit_en && !full;
        mem_ctl.waddr = ncnt_reg[IDX_BITS-1:0];
        mem_ctl.wdata = {emit_l, emit_r};
        if (emit_en)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                ncnt_next = ncnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        ncnt_reg   <= ncnt_next;
        ovf_reg    <= ovf_next;
        placed_reg <= placed_next;
        hit_reg    <= hit_next;
        ml_reg     <= ml_next;
        mr_reg     <= mr_next;
        flo_reg    <= flo_next;
        fhi_reg    <= fhi_next;
        acc_reg    <= acc_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

endmodule

FILE: rtl/closed_interval_set_manager.sv
// Top level of the closed interval set manager: two table banks, the
// sequencer and the result register. Depends on csm_pkg, csm_ram, csm_seq.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_item  (csm_pkg::in_item_t)
//   rsp       out         rsp_valid / rsp_stall  rsp_item  (csm_pkg::out_item_t)
//
// One item at a time. Each stored interval passes through a read state and
// an evaluate state, plus an emit state for the single entry that may emit two
// intervals (an erase split, or the point where an insert places its merged
// range). A reversed range returns without reading the table.
// Reset empties the table (count zero); the banks themselves are not cleared.
// The next item is taken while a result still sits in the output register;
// a stalled result register holds the sequencer until it drains.
module closed_interval_set_manager (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  csm_pkg::in_item_t   req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output csm_pkg::out_item_t  rsp_item
);
    import csm_pkg::*;

    logic                  seq_ready, res_valid, res_take, bank;
    out_item_t             res;
    mem_ctl_t              mem_ctl;
    logic [ENTRY_BITS-1:0] rdata_a, rdata_b, rd_data;
    logic                  rsp_valid_reg, rsp_valid_next;
    out_item_t             rsp_item_reg;

    // The live table sits in bank A when bank is low, else in bank B.
    // Reads hit the live bank, the rebuilt table goes to the other one,
    // so a read and a write never touch the same entry.
    csm_ram #(
        .DEPTH(MAX_INTERVALS),
        .WIDTH(ENTRY_BITS)
    ) u_bank_a (
        .clk  (clk),
        .we   (mem_ctl.we && bank),
        .waddr(mem_ctl.waddr),
        .wdata(mem_ctl.wdata),
        .re   (mem_ctl.re && !bank),
        .raddr(mem_ctl.raddr),
        .rdata(rdata_a)
    );

    csm_ram #(
        .DEPTH(MAX_INTERVALS),
        .WIDTH(ENTRY_BITS)
    ) u_bank_b (
        .clk  (clk),
        .we   (mem_ctl.we && !bank),
        .waddr(mem_ctl.waddr),
        .wdata(mem_ctl.wdata),
        .re   (mem_ctl.re && bank),
        .raddr(mem_ctl.raddr),
        .rdata(rdata_b)
    );

    // Bank only flips at the end of an item, never with a read in flight.
    assign rd_data = bank ? rdata_b : rdata_a;

    csm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req_valid && seq_ready),
        .item     (req_item),
        .ready    (seq_ready),
        .rd_data  (rd_data),
        .mem_ctl  (mem_ctl),
        .bank     (bank),
        .res_valid(res_valid),
        .res      (res),
        .res_take (res_take)
    );

    assign req_stall = !seq_ready;

    // Load the result register whenever it is empty or being drained.
    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_item_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

FILE: rtl/csm_checker.sv
// Port-level checks for the closed interval set manager, bound to the top.
// Depends on csm_pkg and closed_interval_set_manager.
module csm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  csm_pkg::out_item_t  rsp_item
);
    import csm_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("result dropped or changed while stalled");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status != STAT_OK |-> rsp_item.value == '0)
        else $error("nonzero value on a rejected item");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.hit |-> rsp_item.found_lo == '0 && rsp_item.found_hi == '0)
        else $error("found interval reported without a hit");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.interval_count <= CNT_BITS'(MAX_INTERVALS))
        else $error("interval count above table capacity");

    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.hit |-> rsp_item.found_lo <= rsp_item.found_hi)
        else $error("covering interval reversed");

endmodule

bind closed_interval_set_manager csm_checker u_csm_checker (.*);
